[rtl/nid_pkg.sv]
// Shared types and constants of the nested interrupt dispatcher.
`timescale 1ns / 1ps

package nid_pkg;

  localparam int NUM_LINES   = 32;
  localparam int NUM_THREADS = 256;
  localparam int STACK_DEPTH = 16;

  localparam int LINE_W    = 8;
  localparam int THR_W     = 8;
  localparam int LINE_IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int THR_IDX_W  = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int STK_IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LVL_W      = $clog2(STACK_DEPTH + 1);

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    ACT_CREATE  = 3'd0,
    ACT_DESTROY = 3'd1,
    ACT_RAISE   = 3'd2,
    ACT_RETURN  = 3'd3,
    ACT_PUSH    = 3'd4,
    ACT_POP     = 3'd5,
    ACT_RESUME  = 3'd6,
    ACT_READ    = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    ERR_OK         = 4'd0,
    ERR_HOOK       = 4'd1,
    ERR_BAD_IRQ    = 4'd2,
    ERR_HANDLED    = 4'd3,
    ERR_BAD_THREAD = 4'd4,
    ERR_NO_INT     = 4'd5,
    ERR_FULL       = 4'd6,
    ERR_NOT_NEST   = 4'd7,
    ERR_NOT_ACTIVE = 4'd8,
    ERR_NONE       = 4'd9
  } err_t;

  typedef struct packed {
    action_t            action;
    logic [LINE_W-1:0]  irq_line;
    logic [THR_W-1:0]   handler_thread;
    logic               nest_enable;
    logic               thread_exists;
    logic               hook_ok;
    logic [THR_W-1:0]   running_thread;
  } in_item_t;

  typedef struct packed {
    logic               success;
    err_t               error_code;
    logic               switch_valid;
    logic [THR_W-1:0]   switch_thread;
    logic [LINE_W-1:0]  last_irq;
  } result_t;

  typedef struct packed {
    logic load;
    logic look;
    logic commit;
  } dp_cmd_t;

endpackage

[rtl/nested_interrupt_dispatcher_top.sv]
// Top level of the nested interrupt dispatcher.
`timescale 1ns / 1ps

// Each accepted beat runs one operation (create, destroy, raise, return, push,
// pop, resume, read last) and yields exactly one result beat. An operation
// runs as accept, handler table lookup, then execute and commit over the
// flop tables; the block takes no new beat until the current one commits,
// and a commit waits while an earlier result is not yet taken. A finished
// result waits in the output register while the next beat is accepted and
// looked up. No clearing pass follows reset; the block is ready in the first
// cycle after rst_n goes high.
module nested_interrupt_dispatcher_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // irq_line, handler_thread, nest_enable, thread_exists, hook_ok, running_thread
  input  logic [nid_pkg::IN_TDATA_W-1:0]     in_tdata,
  // action
  input  logic [nid_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // success, error_code, switch_valid, switch_thread, last_irq
  output logic [nid_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import nid_pkg::*;

  dp_cmd_t  cmd;
  in_item_t in_item;
  result_t  res;

  always_comb begin
    in_item.action         = action_t'(in_tuser);
    in_item.irq_line       = in_tdata[7:0];
    in_item.handler_thread = in_tdata[15:8];
    in_item.nest_enable    = in_tdata[16];
    in_item.thread_exists  = in_tdata[17];
    in_item.hook_ok        = in_tdata[18];
    in_item.running_thread = in_tdata[26:19];
  end

  assign out_tdata = {2'b00, res.last_irq, res.switch_thread, res.switch_valid,
                      res.error_code, res.success};

  nid_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  nid_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_item (in_item),
    .res     (res)
  );

endmodule

[rtl/nid_ctrl.sv]
// Controller state machine: sequences accept, table lookup and execute.
`timescale 1ns / 1ps

module nid_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output nid_pkg::dp_cmd_t cmd
);
  import nid_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.load   = in_tvalid && in_tready;
    cmd.look   = (state_r == S_LOOK);
    cmd.commit = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/nid_datapath.sv]
// Datapath: handler table, flags, preemption stack and result register.
`timescale 1ns / 1ps

module nid_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  nid_pkg::dp_cmd_t cmd,
  input  nid_pkg::in_item_t in_item,
  output nid_pkg::result_t res
);
  import nid_pkg::*;

  in_item_t               item_r;
  logic [NUM_LINES-1:0]   hvalid_r;
  logic [NUM_LINES-1:0]   nest_flags_r;
  logic [THR_W-1:0]       htab_r [NUM_LINES];
  logic [NUM_THREADS-1:0] active_r;
  logic [THR_W-1:0]       stack_r [STACK_DEPTH];
  logic [LVL_W-1:0]       level_r;
  logic [LINE_W-1:0]      last_r;
  result_t                res_r;

  logic                   hv_l_r;
  logic                   nest_l_r;
  logic [THR_W-1:0]       h_l_r;
  logic                   act_l_r;

  logic [LINE_IDX_W-1:0]  line_idx;
  logic                   line_ok;
  logic                   thr_ok;
  logic                   run_ok;
  logic                   h_ok;
  logic                   lk_h_ok;
  logic [THR_W-1:0]       lk_h;
  logic                   full;
  logic                   empty;
  logic [STK_IDX_W-1:0]   top_idx;
  logic [THR_W-1:0]       top_thr;

  logic                   ok;
  err_t                   err;
  logic                   sw;
  logic [THR_W-1:0]       swt;
  logic                   hv_we;
  logic                   hv_val;
  logic                   tab_we;
  logic                   act_we;
  logic [THR_IDX_W-1:0]   act_idx;
  logic                   act_val;
  logic                   push;
  logic [THR_W-1:0]       push_val;
  logic                   pop;
  logic                   last_we;
  logic [LINE_W-1:0]      last_nxt;

  assign line_idx = item_r.irq_line[LINE_IDX_W-1:0];
  assign line_ok  = {1'b0, item_r.irq_line} < (LINE_W+1)'(NUM_LINES);
  assign thr_ok   = {1'b0, item_r.handler_thread} < (THR_W+1)'(NUM_THREADS);
  assign run_ok   = {1'b0, item_r.running_thread} < (THR_W+1)'(NUM_THREADS);
  assign h_ok     = {1'b0, h_l_r} < (THR_W+1)'(NUM_THREADS);
  assign lk_h     = htab_r[line_idx];
  assign lk_h_ok  = {1'b0, lk_h} < (THR_W+1)'(NUM_THREADS);
  assign full     = level_r >= LVL_W'(STACK_DEPTH);
  assign empty    = (level_r == '0);
  assign top_idx  = STK_IDX_W'(level_r - 1'b1);
  assign top_thr  = stack_r[top_idx];

  always_comb begin
    ok       = 1'b0;
    err      = ERR_NONE;
    sw       = 1'b0;
    swt      = '0;
    hv_we    = 1'b0;
    hv_val   = 1'b0;
    tab_we   = 1'b0;
    act_we   = 1'b0;
    act_idx  = '0;
    act_val  = 1'b0;
    push     = 1'b0;
    push_val = '0;
    pop      = 1'b0;
    last_we  = 1'b0;
    case (item_r.action)
      ACT_CREATE: begin
        if (!line_ok) err = ERR_BAD_IRQ;
        else if (hv_l_r) err = ERR_HANDLED;
        else if (!thr_ok || !item_r.thread_exists) err = ERR_BAD_THREAD;
        else if (!item_r.hook_ok) err = ERR_HOOK;
        else begin
          hv_we   = 1'b1;
          hv_val  = 1'b1;
          tab_we  = 1'b1;
          act_we  = 1'b1;
          act_idx = item_r.handler_thread[THR_IDX_W-1:0];
          act_val = 1'b0;
          ok      = 1'b1;
          err     = ERR_OK;
        end
      end
      ACT_DESTROY: begin
        if (!line_ok) err = ERR_BAD_IRQ;
        else if (!hv_l_r) err = ERR_NONE;
        else if (h_l_r != item_r.handler_thread) err = ERR_BAD_THREAD;
        else if (!item_r.hook_ok) err = ERR_HOOK;
        else begin
          hv_we  = 1'b1;
          hv_val = 1'b0;
          ok     = 1'b1;
          err    = ERR_OK;
        end
      end
      ACT_RAISE: begin
        if (!line_ok) err = ERR_BAD_IRQ;
        else if (!hv_l_r) err = ERR_NO_INT;
        else if ((h_l_r == item_r.running_thread) || act_l_r) err = ERR_NONE;
        else if (nest_l_r && full) err = ERR_FULL;
        else begin
          if (nest_l_r) begin
            push     = 1'b1;
            push_val = item_r.running_thread;
            act_we   = h_ok;
            act_idx  = h_l_r[THR_IDX_W-1:0];
            act_val  = 1'b1;
          end
          last_we = 1'b1;
          sw      = 1'b1;
          swt     = h_l_r;
          ok      = 1'b1;
          err     = ERR_OK;
        end
      end
      ACT_RETURN: begin
        if (empty) err = ERR_NONE;
        else begin
          act_we  = run_ok;
          act_idx = item_r.running_thread[THR_IDX_W-1:0];
          act_val = 1'b0;
          pop     = 1'b1;
          sw      = 1'b1;
          swt     = top_thr;
          ok      = 1'b1;
          err     = ERR_OK;
        end
      end
      ACT_PUSH: begin
        if (!line_ok) err = ERR_BAD_IRQ;
        else if (!hv_l_r) err = ERR_NO_INT;
        else if (h_l_r == item_r.running_thread) err = ERR_BAD_THREAD;
        else if (!act_l_r) err = ERR_NOT_ACTIVE;
        else if (!nest_l_r) err = ERR_NOT_NEST;
        else if (full) err = ERR_FULL;
        else begin
          push     = 1'b1;
          push_val = h_l_r;
          last_we  = 1'b1;
          ok       = 1'b1;
          err      = ERR_OK;
        end
      end
      ACT_POP: begin
        if (empty) err = ERR_NO_INT;
        else begin
          pop = 1'b1;
          ok  = 1'b1;
          err = ERR_OK;
        end
      end
      ACT_RESUME: begin
        if (empty) err = ERR_NO_INT;
        else begin
          sw  = 1'b1;
          swt = top_thr;
          ok  = 1'b1;
          err = ERR_OK;
        end
      end
      ACT_READ: begin
        ok  = 1'b1;
        err = ERR_OK;
      end
      default: begin
        ok  = 1'b0;
        err = ERR_NONE;
      end
    endcase
  end

  assign last_nxt = last_we ? item_r.irq_line : last_r;

  // hold the beat, look up the handler entry, and on commit write the handler table, stack and result
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.look) begin
      hv_l_r   <= hvalid_r[line_idx];
      nest_l_r <= nest_flags_r[line_idx];
      h_l_r    <= lk_h;
      act_l_r  <= lk_h_ok && active_r[lk_h[THR_IDX_W-1:0]];
    end
    if (cmd.commit) begin
      if (tab_we) htab_r[line_idx] <= item_r.handler_thread;
      if (push) stack_r[level_r[STK_IDX_W-1:0]] <= push_val;
      res_r.success       <= ok;
      res_r.error_code    <= err;
      res_r.switch_valid  <= sw;
      res_r.switch_thread <= swt;
      res_r.last_irq      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvalid_r     <= '0;
      nest_flags_r <= '0;
      active_r     <= '0;
      level_r      <= '0;
      last_r       <= '0;
    end else if (cmd.commit) begin
      if (hv_we) hvalid_r[line_idx] <= hv_val;
      if (tab_we) nest_flags_r[line_idx] <= item_r.nest_enable;
      if (act_we) active_r[act_idx] <= act_val;
      if (push) level_r <= level_r + 1'b1;
      else if (pop) level_r <= level_r - 1'b1;
      last_r <= last_nxt;
    end
  end

  assign res = res_r;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(push && pop))
    else $error("push and pop in one commit");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(level_r) && $stable(last_r) && $stable(hvalid_r))
    else $error("state changed without commit");

  a_switch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (res_r.switch_valid || (res_r.switch_thread == '0)))
    else $error("switch thread set without switch request");

  a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (res_r.success == (res_r.error_code == ERR_OK)))
    else $error("success and error code disagree");
`endif

endmodule
